// ----- rtl/core/bitmap_block_allocator_unit_defines.svh -----
// Assertion macros shared by the bitmap block allocator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBA_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bba_pkg.sv -----
// Package for the bitmap block allocator: default sizes, codes and state type.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package bba_pkg;

    // Default capacity and bitmap word width (the word width must be a power of two).
    localparam int DEF_MAX_BLOCKS = 2048;
    localparam int DEF_WORD_BITS  = 64;

    typedef enum logic [1:0] {
        ACT_ALLOC = 2'd0,
        ACT_FREE  = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK           = 2'd0,
        STAT_NO_FREE      = 2'd1,
        STAT_RANGE        = 2'd2,
        STAT_ALREADY_FREE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_RD,
        S_FREE_CHK,
        S_WRITE,
        S_RESP
    } state_t;

endpackage

// ----- rtl/core/bba_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing; holds the usage bitmap words.
`timescale 1ns / 1ps

module bba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/bba_find.sv -----
// Lowest-clear-bit priority encoder over one bitmap word.
// Depends on nothing; used by the top level during the free-block scan.
`timescale 1ns / 1ps

module bba_find #(
    parameter int WORD_BITS = 64,
    localparam int IDX_W    = $clog2(WORD_BITS)
) (
    input  logic [WORD_BITS-1:0] word,
    output logic                 found,
    output logic [IDX_W-1:0]     idx
);

    // Walk from the top bit down so that the lowest clear bit wins.
    always_comb begin
        found = 1'b0;
        idx   = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

// ----- rtl/core/bitmap_block_allocator_unit.sv -----
// Top level of the first-fit bitmap block allocator.
// Depends on bba_pkg, bba_ram, bba_find and bitmap_block_allocator_unit_defines.svh.
//
//   Channel   Direction  Word contents
//   s_        in         action, block_number
//   m_        out        status, granted_block, used_blocks, free_blocks
//   cfg_      in         block_count (write also clears the allocator)
//
// Allocate scans the bitmap upward from word 0 to the lowest word with a clear bit;
// the scan reads one word per cycle from the RAM. Free reads, checks and writes back
// the word, skipping the write when the block is already free; clear, the unused action,
// an allocate with nothing free and an out-of-range free go straight to the response.
// Reset is synchronous; per-word valid flags make all words read as free at once,
// so there is no clearing pass. A result word waiting on m_ready does not stop the
// next s_ word being taken; the following result then waits for the output register.
`timescale 1ns / 1ps

module bitmap_block_allocator_unit
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS,
    parameter int WORD_BITS  = DEF_WORD_BITS,
    localparam int NUM_W     = $clog2(MAX_BLOCKS),
    localparam int CNT_W     = $clog2(MAX_BLOCKS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Request channel
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [1:0]       s_action,
    input  logic [NUM_W-1:0] s_block_number,
    // Result channel
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_status,
    output logic [NUM_W-1:0] m_granted_block,
    output logic [CNT_W-1:0] m_used_blocks,
    output logic [CNT_W-1:0] m_free_blocks,
    // Configuration channel
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [CNT_W-1:0] cfg_data
);

`include "bitmap_block_allocator_unit_defines.svh"

    localparam int MAP_WORDS = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(WORD_BITS);

    // Control state
    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     block_count_reg;
    logic [CNT_W-1:0]     used_reg;
    logic [CNT_W-1:0]     free_reg;
    logic [MAP_WORDS-1:0] word_valid_reg;
    logic [WA_W:0]        scan_addr_reg;
    logic                 chk_valid_reg;
    logic                 m_valid_reg;

    // Payload registers
    logic [WA_W-1:0]      chk_addr_reg;
    logic                 rd_valid_reg;
    logic [WA_W-1:0]      fword_reg;
    logic [BIT_W-1:0]     fbit_reg;
    logic [WA_W-1:0]      wr_addr_reg;
    logic [WORD_BITS-1:0] wr_data_reg;
    status_t              res_status_reg;
    logic [NUM_W-1:0]     res_granted_reg;
    status_t              m_status_reg;
    logic [NUM_W-1:0]     m_granted_reg;
    logic [CNT_W-1:0]     m_used_reg;
    logic [CNT_W-1:0]     m_free_reg;

    // Combinational signals
    logic                   s_fire;
    logic                   cfg_fire;
    logic                   out_free;
    action_t                req_action;
    logic [CNT_W-1:0]       eff_count;
    logic [CNT_W-1:0]       cfg_eff_count;
    logic                   num_in_range;
    logic [NUM_W+BIT_W-1:0] num_ext;
    logic                   rd_en;
    logic [WA_W-1:0]        rd_addr;
    logic [WORD_BITS-1:0]   rd_data;
    logic [WORD_BITS-1:0]   word_data;
    logic                   wr_en;
    logic                   find_found;
    logic [BIT_W-1:0]       find_idx;
    logic                   scan_issue;
    logic                   chk_last;
    logic [WA_W+BIT_W-1:0]  found_block;

    // Handshakes and request decoding.
    assign s_fire     = s_valid && s_ready;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign out_free   = !m_valid_reg || m_ready;
    assign req_action = action_t'(s_action);

    // Counts above the capacity saturate to the capacity.
    assign eff_count     = (block_count_reg > CNT_W'(MAX_BLOCKS)) ?
                           CNT_W'(MAX_BLOCKS) : block_count_reg;
    assign cfg_eff_count = (cfg_data > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : cfg_data;
    assign num_in_range  = CNT_W'(s_block_number) < eff_count;
    assign num_ext       = (NUM_W + BIT_W)'(s_block_number);

    // Scan bookkeeping; words never written since the last clear read as all free.
    assign scan_issue  = scan_addr_reg < (WA_W + 1)'(MAP_WORDS);
    assign chk_last    = chk_addr_reg == WA_W'(MAP_WORDS - 1);
    assign word_data   = rd_valid_reg ? rd_data : '0;
    assign found_block = {chk_addr_reg, find_idx};

    bba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_bitmap (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr_reg),
        .wr_data (wr_data_reg),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    bba_find #(
        .WORD_BITS (WORD_BITS)
    ) u_find (
        .word  (word_data),
        .found (find_found),
        .idx   (find_idx)
    );

    // Next-state logic.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (req_action)
                        ACT_ALLOC: state_next = (free_reg == '0) ? S_RESP : S_SCAN;
                        ACT_FREE:  state_next = num_in_range ? S_FREE_RD : S_RESP;
                        default:   state_next = S_RESP;
                    endcase
                end
            end
            S_SCAN: begin
                if (chk_valid_reg && find_found) begin
                    state_next = S_WRITE;
                end else if (chk_valid_reg && chk_last) begin
                    state_next = S_RESP;
                end
            end
            S_FREE_RD:  state_next = S_FREE_CHK;
            S_FREE_CHK: state_next = word_data[fbit_reg] ? S_WRITE : S_RESP;
            S_WRITE:    state_next = S_RESP;
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // Output and memory control decoding.
    always_comb begin
        s_ready   = 1'b0;
        cfg_ready = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = fword_reg;
        wr_en     = 1'b0;
        case (state_reg)
            S_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
            end
            S_SCAN: begin
                rd_en   = scan_issue;
                rd_addr = scan_addr_reg[WA_W-1:0];
            end
            S_FREE_RD: rd_en = 1'b1;
            S_WRITE:   wr_en = 1'b1;
            default: begin
                rd_en = 1'b0;
            end
        endcase
    end

    // Control registers: state, counters, valid flags and scan pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            block_count_reg <= CNT_W'(MAX_BLOCKS);
            used_reg        <= '0;
            free_reg        <= CNT_W'(MAX_BLOCKS);
            word_valid_reg  <= '0;
            scan_addr_reg   <= '0;
            chk_valid_reg   <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;

            if (cfg_fire) begin
                block_count_reg <= cfg_data;
                used_reg        <= '0;
                free_reg        <= cfg_eff_count;
                word_valid_reg  <= '0;
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_fire && req_action == ACT_ALLOC) begin
                        scan_addr_reg <= '0;
                        chk_valid_reg <= 1'b0;
                    end
                    if (s_fire && req_action == ACT_CLEAR) begin
                        used_reg       <= '0;
                        free_reg       <= eff_count;
                        word_valid_reg <= '0;
                    end
                end
                S_SCAN: begin
                    chk_valid_reg <= scan_issue;
                    if (scan_issue) begin
                        scan_addr_reg <= scan_addr_reg + 1'b1;
                    end
                    if (chk_valid_reg && find_found) begin
                        used_reg <= used_reg + 1'b1;
                        free_reg <= free_reg - 1'b1;
                    end
                end
                S_FREE_CHK: begin
                    if (word_data[fbit_reg]) begin
                        if (used_reg != '0) begin
                            used_reg <= used_reg - 1'b1;
                        end
                        free_reg <= free_reg + 1'b1;
                    end
                end
                S_WRITE: word_valid_reg[wr_addr_reg] <= 1'b1;
                default: begin
                    chk_valid_reg <= 1'b0;
                end
            endcase

            // Output register: loads from the response state, otherwise drains on m_ready.
            if (state_reg == S_RESP && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: request fields, read-modify-write word and results.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    fword_reg       <= WA_W'(num_ext >> BIT_W);
                    fbit_reg        <= num_ext[BIT_W-1:0];
                    res_granted_reg <= '0;
                    if (req_action == ACT_ALLOC && free_reg == '0) begin
                        res_status_reg <= STAT_NO_FREE;
                    end else if (req_action == ACT_FREE && !num_in_range) begin
                        res_status_reg <= STAT_RANGE;
                    end else begin
                        res_status_reg <= STAT_OK;
                    end
                end
            end
            S_SCAN: begin
                chk_addr_reg <= scan_addr_reg[WA_W-1:0];
                if (chk_valid_reg && find_found) begin
                    wr_addr_reg     <= chk_addr_reg;
                    wr_data_reg     <= word_data | (WORD_BITS'(1) << find_idx);
                    res_granted_reg <= NUM_W'(found_block);
                end else if (chk_valid_reg && chk_last) begin
                    res_status_reg <= STAT_NO_FREE;
                end
            end
            S_FREE_CHK: begin
                wr_addr_reg <= fword_reg;
                wr_data_reg <= word_data & ~(WORD_BITS'(1) << fbit_reg);
                if (!word_data[fbit_reg]) begin
                    res_status_reg <= STAT_ALREADY_FREE;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    m_status_reg  <= res_status_reg;
                    m_granted_reg <= res_granted_reg;
                    m_used_reg    <= used_reg;
                    m_free_reg    <= free_reg;
                end
            end
            default: begin
                wr_addr_reg <= wr_addr_reg;
            end
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_block = m_granted_reg;
    assign m_used_blocks   = m_used_reg;
    assign m_free_blocks   = m_free_reg;

    // Used and free counts always add up to the managed block count.
    `BBA_ASSERT_SAME(a_count_sum, aclk, aresetn, 1'b1, ((CNT_W + 1)'(used_reg) + (CNT_W + 1)'(free_reg)) == (CNT_W + 1)'(eff_count), "used and free counts disagree with the block count")
    // Only a successful allocation reports a non-zero block.
    `BBA_ASSERT_SAME(a_grant_zero, aclk, aresetn, m_valid_reg && m_status_reg != STAT_OK, m_granted_reg == '0, "block number reported on a failed request")
    // A request is taken one at a time.
    `BBA_ASSERT_NEXT(a_one_at_a_time, aclk, aresetn, s_valid && s_ready, !s_ready, "second request taken while one is in progress")

endmodule

// ----- tb/sv/block_grant_checker.sv -----
// Checker for the bitmap block allocator: follows the request, result and
// configuration channels, predicts each result word and compares it.
// Depends on bba_pkg for the action and status codes and default sizes.
`timescale 1ns / 1ps

module block_grant_checker
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [1:0]                       s_action,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    s_block_number,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [1:0]                       m_status,
    input  logic [$clog2(MAX_BLOCKS)-1:0]    m_granted_block,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  m_used_blocks,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  m_free_blocks,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  cfg_data,
    output int unsigned                      grant_errors,
    output int unsigned                      grants_outstanding
);

    localparam int NUM_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        status_t          status;
        logic [NUM_W-1:0] granted;
        logic [CNT_W-1:0] used;
        logic [CNT_W-1:0] spare;
    } grant_word_t;

    // Private copy of the allocator state.
    logic [MAX_BLOCKS-1:0] usage_map;
    logic [CNT_W-1:0]      block_count_reg;
    logic [CNT_W-1:0]      used_cnt;
    logic [CNT_W-1:0]      spare_cnt;

    grant_word_t pending_grants[$];

    initial grant_errors = 0;
    initial grants_outstanding = 0;

    // A programmed count above the bitmap capacity saturates to the capacity.
    function automatic int unsigned managed_blocks();
        return (block_count_reg > MAX_BLOCKS) ? MAX_BLOCKS : block_count_reg;
    endfunction

    function automatic void wipe_map();
        usage_map = '0;
        used_cnt  = '0;
        spare_cnt = CNT_W'(managed_blocks());
    endfunction

    // Applies one request word to the private state and returns the result word.
    function automatic grant_word_t predict_grant(input action_t act,
                                                  input logic [NUM_W-1:0] num);
        grant_word_t w;
        int unsigned limit;
        logic        found;
        limit     = managed_blocks();
        w.status  = STAT_OK;
        w.granted = '0;
        found     = 1'b0;
        case (act)
            ACT_ALLOC: begin
                // First fit: the lowest-numbered clear bit below the managed count.
                if (spare_cnt != 0) begin
                    for (int b = 0; b < limit && !found; b++) begin
                        if (!usage_map[b]) begin
                            found     = 1'b1;
                            w.granted = NUM_W'(b);
                        end
                    end
                end
                if (found) begin
                    usage_map[w.granted] = 1'b1;
                    used_cnt  = used_cnt + 1'b1;
                    spare_cnt = spare_cnt - 1'b1;
                end else begin
                    w.status = STAT_NO_FREE;
                end
            end
            ACT_FREE: begin
                if (num >= limit) begin
                    w.status = STAT_RANGE;
                end else if (!usage_map[num]) begin
                    w.status = STAT_ALREADY_FREE;
                end else begin
                    usage_map[num] = 1'b0;
                    if (used_cnt != 0)
                        used_cnt = used_cnt - 1'b1;
                    spare_cnt = spare_cnt + 1'b1;
                end
            end
            ACT_CLEAR: begin
                wipe_map();
            end
            default: begin
            end
        endcase
        w.used  = used_cnt;
        w.spare = spare_cnt;
        return w;
    endfunction

    function automatic void note_failure(input string what, input grant_word_t want,
                                         input grant_word_t seen);
        grant_errors++;
        if (grant_errors <= MAX_REPORTS)
            $display("%0t %s: expected status %0d block %0d used %0d free %0d, got status %0d block %0d used %0d free %0d",
                     $realtime, what, want.status, want.granted, want.used, want.spare,
                     seen.status, seen.granted, seen.used, seen.spare);
    endfunction

    // Results are handled before requests: a result word taken at this edge
    // always belongs to a request word accepted at an earlier edge.
    always @(posedge aclk) begin : watch
        grant_word_t seen;
        grant_word_t want;
        if (!aresetn) begin
            block_count_reg = CNT_W'(MAX_BLOCKS);
            wipe_map();
            pending_grants.delete();
        end else begin
            if (m_valid && m_ready) begin
                seen.status  = status_t'(m_status);
                seen.granted = m_granted_block;
                seen.used    = m_used_blocks;
                seen.spare   = m_free_blocks;
                if (pending_grants.size() == 0) begin
                    note_failure("unexpected result", '0, seen);
                end else begin
                    want = pending_grants.pop_front();
                    if (want.status !== seen.status || want.granted !== seen.granted ||
                        want.used !== seen.used || want.spare !== seen.spare)
                        note_failure("result mismatch", want, seen);
                end
            end
            if (cfg_valid && cfg_ready) begin
                block_count_reg = cfg_data;
                wipe_map();
            end
            if (s_valid && s_ready)
                pending_grants.push_back(predict_grant(action_t'(s_action), s_block_number));
        end
        grants_outstanding = pending_grants.size();
    end

endmodule

// ----- tb/sv/tb_bitmap_block_allocator_unit.sv -----
// Testbench top for the bitmap block allocator: clock, reset, request and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on bba_pkg, bitmap_block_allocator_unit and block_grant_checker.
`timescale 1ns / 1ps

module tb_bitmap_block_allocator_unit;
    import bba_pkg::*;

    localparam int NUM_W       = $clog2(DEF_MAX_BLOCKS);
    localparam int CNT_W       = $clog2(DEF_MAX_BLOCKS + 1);
    localparam int IDLE_GUARD  = 48;
    localparam int CYCLE_LIMIT = 1000000;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_JITTER,
        RX_BURSTY
    } rx_mode_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    action_t          s_action = ACT_NONE;
    logic [NUM_W-1:0] s_block_number = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_status;
    logic [NUM_W-1:0] m_granted_block;
    logic [CNT_W-1:0] m_used_blocks;
    logic [CNT_W-1:0] m_free_blocks;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [CNT_W-1:0] cfg_data = '0;

    int unsigned grant_errors;
    int unsigned grants_outstanding;
    int unsigned cycle_count = 0;
    int unsigned burst_left = 1;
    bit          line_held = 1'b0;

    rx_mode_t    rx_mode = RX_STEADY;
    int unsigned rx_span = 0;
    int unsigned rx_hold = 0;
    bit          rx_stalled = 1'b0;

    bitmap_block_allocator_unit u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_block_number  (s_block_number),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_granted_block (m_granted_block),
        .m_used_blocks   (m_used_blocks),
        .m_free_blocks   (m_free_blocks),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_data        (cfg_data)
    );

    block_grant_checker u_checker (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_block_number     (s_block_number),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_granted_block    (m_granted_block),
        .m_used_blocks      (m_used_blocks),
        .m_free_blocks      (m_free_blocks),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .grant_errors       (grant_errors),
        .grants_outstanding (grants_outstanding)
    );

    // 8 ns clock.
    initial begin
        forever #4 aclk = ~aclk;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver changes its stall habit at random: always ready, random
    // stalls in single cycles, or alternating stretches of stalls and readiness.
    always @(negedge aclk) begin
        if (rx_span == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 2));
            rx_span = $urandom_range(32, 256);
        end
        rx_span--;
        case (rx_mode)
            RX_STEADY: begin
                m_ready <= 1'b1;
            end
            RX_JITTER: begin
                m_ready <= ($urandom_range(0, 2) != 0);
            end
            default: begin
                if (rx_hold == 0) begin
                    rx_stalled = !rx_stalled;
                    rx_hold    = $urandom_range(1, 20);
                end
                rx_hold--;
                m_ready <= !rx_stalled;
            end
        endcase
    end

    // Presents one request word and holds it until it is taken. The line stays
    // high into the next word within a burst and drops for a gap at its end.
    task automatic send_request(input action_t act, input logic [NUM_W-1:0] num);
        s_valid        <= 1'b1;
        s_action       <= act;
        s_block_number <= num;
        line_held      = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            s_valid   <= 1'b0;
            line_held = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(64, 200)
                                                      : $urandom_range(1, 24);
        end
    endtask

    task automatic release_request_line();
        if (line_held) begin
            s_valid   <= 1'b0;
            line_held = 1'b0;
        end
    endtask

    // Waits until every result is back and the block has settled, then
    // programs the block count, which also clears the allocator.
    task automatic write_block_count(input logic [CNT_W-1:0] value);
        release_request_line();
        while (grants_outstanding != 0) @(negedge aclk);
        repeat (IDLE_GUARD) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // A random phase: programs the count, then sends a weighted mix of
    // actions. Most free numbers fall near the managed range.
    task automatic run_mix(input int unsigned blocks, input int unsigned n,
                           input int unsigned alloc_pct, input int unsigned free_pct,
                           input int unsigned clear_pct);
        int unsigned      span;
        int unsigned      roll;
        action_t          act;
        logic [NUM_W-1:0] num;
        write_block_count(CNT_W'(blocks));
        span = (blocks > (DEF_MAX_BLOCKS - 1)) ? (DEF_MAX_BLOCKS - 1) : blocks;
        repeat (n) begin
            roll = $urandom_range(0, 99);
            if (roll < alloc_pct)
                act = ACT_ALLOC;
            else if (roll < alloc_pct + free_pct)
                act = ACT_FREE;
            else if (roll < alloc_pct + free_pct + clear_pct)
                act = ACT_CLEAR;
            else
                act = ACT_NONE;
            if ($urandom_range(0, 4) != 0)
                num = NUM_W'($urandom_range(0, span));
            else
                num = NUM_W'($urandom_range(0, DEF_MAX_BLOCKS - 1));
            send_request(act, num);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Small pool: fill it, run out, then free out of range, free twice,
        // refill the hole, an unused action and a clear.
        write_block_count(CNT_W'(8));
        repeat (9) send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, NUM_W'(8));
        send_request(ACT_FREE, NUM_W'(3));
        send_request(ACT_FREE, NUM_W'(3));
        send_request(ACT_ALLOC, '1);
        send_request(ACT_FREE, '1);
        send_request(ACT_NONE, '1);
        send_request(ACT_CLEAR, '1);
        send_request(ACT_FREE, '0);

        // A count of zero manages no blocks at all.
        write_block_count('0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, '0);

        // An oversized count saturates to the full capacity.
        write_block_count('1);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, '1);

        // A single block.
        write_block_count(CNT_W'(1));
        send_request(ACT_ALLOC, '0);
        send_request(ACT_ALLOC, '0);
        send_request(ACT_FREE, NUM_W'(1));

        // A long run at full capacity that pushes the scan well into the
        // bitmap, followed by phases at assorted counts.
        run_mix(DEF_MAX_BLOCKS, 900, 98, 1, 0);
        run_mix(1, 40, 50, 45, 3);
        run_mix(300, 250, 60, 35, 2);
        run_mix(DEF_MAX_BLOCKS - 1, 100, 50, 40, 5);
        run_mix(0, 20, 50, 45, 3);
        run_mix(64, 100, 55, 40, 3);
        run_mix(65, 80, 55, 40, 3);

        release_request_line();
        while (grants_outstanding != 0) @(negedge aclk);
        repeat (IDLE_GUARD) @(negedge aclk);

        if (grant_errors == 0 && grants_outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
